FILE: design/spq_pkg.sv
// Shared types and codes for the sorted priority queue core.
// Holds the sequencer state type, operation codes and status codes.
// No dependencies.
`default_nettype none

package spq_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_COMPACT,
      S_INSERT,
      S_HEAD_RD,
      S_HEAD_WT,
      S_RESP
   } st_type;

   localparam logic [2:0] OP_ENQ  = 3'd0;
   localparam logic [2:0] OP_DEQ  = 3'd1;
   localparam logic [2:0] OP_RNG  = 3'd2;
   localparam logic [2:0] OP_FIND = 3'd3;
   localparam logic [2:0] OP_CHG  = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

FILE: design/sorted_priority_queue_core.sv
// Sorted priority queue core: sorted store in a one-read one-write memory,
// walked entry by entry under a small sequencer. Depends on spq_pkg.
//
//  channel | direction | handshake           | word
//  req_    | in        | req_valid/req_stall | op, tag, priority, bounds, new priority
//  rsp_    | out       | rsp_valid/rsp_stall | status, tag, priority, counts, head
//
// One operation at a time; req_stall is high from acceptance until the
// response word is taken. After acceptance a word passes through a tag/duplicate
// scan, a compaction and/or a top-down insert, each stepping through the entries held
// one at a time over the memory's single read port, then a head read and the response.
// Reset clears the sequencer state, the read-valid flag and the entry count; the store needs no clearing.
// A stalled response holds every rsp_ field.
`default_nettype none

module sorted_priority_queue_core #(
   parameter int DEPTH  = 16,
   parameter int TAG_W  = 32,
   parameter int PRIO_W = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [2:0]                    req_op,
   input  wire logic [TAG_W-1:0]              req_data_in,
   input  wire logic [PRIO_W-1:0]             req_priority_in,
   input  wire logic [PRIO_W-1:0]             req_low_bound,
   input  wire logic [PRIO_W-1:0]             req_high_bound,
   input  wire logic [PRIO_W-1:0]             req_new_priority,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic [TAG_W-1:0]                   rsp_data_out,
   output logic [PRIO_W-1:0]                  rsp_found_priority,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_removed_count,
   output logic [TAG_W-1:0]                   rsp_head_data,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_total,
   output logic                               rsp_is_empty_flag
);
   import spq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [PRIO_W-1:0] mem_prio_ff [DEPTH];
   logic [TAG_W-1:0]  mem_tag_ff  [DEPTH];
   logic [PRIO_W-1:0] rd_p_ff;
   logic [TAG_W-1:0]  rd_t_ff;

   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic              we;
   logic [IW-1:0]     wa;
   logic [PRIO_W-1:0] wp;
   logic [TAG_W-1:0]  wt;

   st_type state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [PRIO_W-1:0] prio_ff, prio_in, lo_ff, lo_in, hi_ff, hi_in, np_ff, np_in;
   logic [CW-1:0]     cnt_ff, cnt_in, iss_ff, iss_in, wj_ff, wj_in, rcnt_ff, rcnt_in;
   logic              pv_ff, pv_in, found_ff, found_in, dup_ff, dup_in;
   logic [IW-1:0]     pidx_ff, pidx_in, pos_ff, pos_in;
   logic [PRIO_W-1:0] fnd_p_ff, fnd_p_in, fprio_ff, fprio_in, ins_p_ff, ins_p_in;
   logic [TAG_W-1:0]  ins_t_ff, ins_t_in, dout_ff, dout_in, head_ff, head_in;
   logic [2:0]        stat_ff, stat_in;

   logic              drop;
   logic [PRIO_W-1:0] cmp_p;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_p_ff <= mem_prio_ff[rd_addr];
         rd_t_ff <= mem_tag_ff[rd_addr];
      end
      if (we) begin
         mem_prio_ff[wa] <= wp;
         mem_tag_ff[wa]  <= wt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
      end
      op_ff    <= op_in;
      tag_ff   <= tag_in;
      prio_ff  <= prio_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      np_ff    <= np_in;
      iss_ff   <= iss_in;
      wj_ff    <= wj_in;
      rcnt_ff  <= rcnt_in;
      found_ff <= found_in;
      dup_ff   <= dup_in;
      pidx_ff  <= pidx_in;
      pos_ff   <= pos_in;
      fnd_p_ff <= fnd_p_in;
      fprio_ff <= fprio_in;
      ins_p_ff <= ins_p_in;
      ins_t_ff <= ins_t_in;
      dout_ff  <= dout_in;
      head_ff  <= head_in;
      stat_ff  <= stat_in;
   end

   assign cmp_p = (op_ff == OP_ENQ) ? prio_ff : np_ff;

   always_comb begin
      case (op_ff)
         OP_DEQ:  drop = (pidx_ff == '0);
         OP_RNG:  drop = (rd_p_ff >= lo_ff) && (rd_p_ff <= hi_ff);
         OP_CHG:  drop = (pidx_ff == pos_ff);
         default: drop = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      tag_in   = tag_ff;
      prio_in  = prio_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      np_in    = np_ff;
      cnt_in   = cnt_ff;
      iss_in   = iss_ff;
      wj_in    = wj_ff;
      rcnt_in  = rcnt_ff;
      pv_in    = 1'b0;
      found_in = found_ff;
      dup_in   = dup_ff;
      pidx_in  = pidx_ff;
      pos_in   = pos_ff;
      fnd_p_in = fnd_p_ff;
      fprio_in = fprio_ff;
      ins_p_in = ins_p_ff;
      ins_t_in = ins_t_ff;
      dout_in  = dout_ff;
      head_in  = head_ff;
      stat_in  = stat_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      we       = 1'b0;
      wa       = '0;
      wp       = rd_p_ff;
      wt       = rd_t_ff;
      req_stall = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_RESP);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               tag_in   = req_data_in;
               prio_in  = req_priority_in;
               lo_in    = req_low_bound;
               hi_in    = req_high_bound;
               np_in    = req_new_priority;
               iss_in   = '0;
               wj_in    = '0;
               rcnt_in  = '0;
               found_in = 1'b0;
               dup_in   = 1'b0;
               fprio_in = '0;
               dout_in  = '0;
               stat_in  = ST_OK;
               case (req_op)
                  OP_ENQ: begin
                     if (cnt_ff == CW'(DEPTH)) begin
                        stat_in  = ST_FULL;
                        state_in = S_HEAD_RD;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_DEQ: begin
                     if (cnt_ff == '0) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_HEAD_RD;
                     end else begin
                        state_in = S_COMPACT;
                     end
                  end
                  OP_RNG:  state_in = S_COMPACT;
                  OP_FIND: state_in = S_SCAN;
                  OP_CHG:  state_in = S_SCAN;
                  default: state_in = S_HEAD_RD;
               endcase
            end
         end

         S_SCAN: begin
            if (iss_ff != cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = iss_ff[IW-1:0];
               iss_in  = iss_ff + CW'(1);
               pv_in   = 1'b1;
               pidx_in = iss_ff[IW-1:0];
            end
            if (pv_ff) begin
               // first tag hit is the target entry and is exempt from the duplicate test
               if (op_ff != OP_ENQ && !found_ff && rd_t_ff == tag_ff) begin
                  found_in = 1'b1;
                  pos_in   = pidx_ff;
                  fnd_p_in = rd_p_ff;
               end else if (rd_p_ff == cmp_p) begin
                  dup_in = 1'b1;
               end
            end
            if (iss_ff == cnt_ff && !pv_ff) begin
               state_in = S_HEAD_RD;
               case (op_ff)
                  OP_ENQ: begin
                     if (dup_ff) begin
                        stat_in = ST_DUP;
                     end else begin
                        ins_p_in = prio_ff;
                        ins_t_in = tag_ff;
                        iss_in   = cnt_ff;
                        state_in = S_INSERT;
                     end
                  end
                  OP_FIND: begin
                     if (found_ff) fprio_in = fnd_p_ff;
                     else stat_in = ST_NOTFOUND;
                  end
                  default: begin
                     if (!found_ff) begin
                        stat_in = ST_NOTFOUND;
                     end else if (dup_ff) begin
                        stat_in = ST_DUP;
                     end else if (fnd_p_ff != np_ff) begin
                        ins_p_in = np_ff;
                        ins_t_in = tag_ff;
                        iss_in   = '0;
                        wj_in    = '0;
                        state_in = S_COMPACT;
                     end
                  end
               endcase
            end
         end

         S_COMPACT: begin
            if (iss_ff != cnt_ff) begin
               rd_en   = 1'b1;
               rd_addr = iss_ff[IW-1:0];
               iss_in  = iss_ff + CW'(1);
               pv_in   = 1'b1;
               pidx_in = iss_ff[IW-1:0];
            end
            if (pv_ff) begin
               if (drop) begin
                  if (op_ff == OP_RNG) rcnt_in = rcnt_ff + CW'(1);
                  if (op_ff == OP_DEQ) dout_in = rd_t_ff;
               end else begin
                  // write never overtakes the read pointer
                  we    = 1'b1;
                  wa    = wj_ff[IW-1:0];
                  wj_in = wj_ff + CW'(1);
               end
            end
            if (iss_ff == cnt_ff && !pv_ff) begin
               cnt_in = wj_ff;
               if (op_ff == OP_CHG) begin
                  iss_in   = wj_ff;
                  state_in = S_INSERT;
               end else begin
                  state_in = S_HEAD_RD;
               end
            end
         end

         S_INSERT: begin
            // walk down from the tail, moving each lower entry up one slot
            if (iss_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = IW'(iss_ff - CW'(1));
               iss_in  = iss_ff - CW'(1);
               pv_in   = 1'b1;
               pidx_in = IW'(iss_ff - CW'(1));
            end
            if (pv_ff) begin
               we = 1'b1;
               wa = pidx_ff + IW'(1);
               if (rd_p_ff >= ins_p_ff) begin
                  wp       = ins_p_ff;
                  wt       = ins_t_ff;
                  cnt_in   = cnt_ff + CW'(1);
                  pv_in    = 1'b0;
                  state_in = S_HEAD_RD;
               end
            end else if (iss_ff == '0) begin
               we       = 1'b1;
               wa       = '0;
               wp       = ins_p_ff;
               wt       = ins_t_ff;
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_HEAD_RD;
            end
         end

         S_HEAD_RD: begin
            if (cnt_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = S_HEAD_WT;
            end else begin
               head_in  = '0;
               state_in = S_RESP;
            end
         end

         S_HEAD_WT: begin
            head_in  = rd_t_ff;
            state_in = S_RESP;
         end

         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_status         = stat_ff;
   assign rsp_data_out       = dout_ff;
   assign rsp_found_priority = fprio_ff;
   assign rsp_removed_count  = rcnt_ff;
   assign rsp_head_data      = head_ff;
   assign rsp_entry_total    = cnt_ff;
   assign rsp_is_empty_flag  = (cnt_ff == '0);

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_accept_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("response raised in the cycle after acceptance");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      (we && state_ff == S_COMPACT) |-> (wj_ff[IW-1:0] <= pidx_ff))
      else $error("compaction write ahead of read");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (cnt_ff < CW'(DEPTH)))
      else $error("insert into a full store");

endmodule

`default_nettype wire
